// File: hdl/session_token_table_top_assert.svh
// Assertion macros for the session token table.
`ifndef SESSION_TOKEN_TABLE_TOP_ASSERT_SVH
`define SESSION_TOKEN_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define STT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("session table check failed");

// Next-cycle implication, checked out of reset.
`define STT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("session table sequence check failed");

`endif

// File: hdl/stt_pkg.sv
package stt_pkg;

    localparam int SESSIONS    = 8;
    localparam int TOKEN_CHARS = 12;
    localparam int TOKEN_W     = 60;
    localparam int KEY_W       = 5 * TOKEN_CHARS;
    localparam int TIME_W      = 32;
    localparam int CNT_W       = 4;
    localparam int IDX_W       = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1800000;

    typedef enum logic [1:0] {
        KIND_STORE,
        KIND_VALIDATE,
        KIND_REFRESH,
        KIND_INVALIDATE
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_COUNT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic empty;
        logic expired;
        logic live;
        logic match;
    } slot_eval_t;

endpackage

// File: hdl/stt_slot_eval.sv
module stt_slot_eval (
    input  logic [stt_pkg::KEY_W-1:0]  slot_key,
    input  logic [stt_pkg::TIME_W-1:0] slot_lu,
    input  logic [stt_pkg::KEY_W-1:0]  req_key,
    input  logic [stt_pkg::TIME_W-1:0] now_ms,
    input  logic [stt_pkg::TIME_W-1:0] timeout_ms,
    output stt_pkg::slot_eval_t        ev
);

    logic [stt_pkg::TIME_W-1:0] age;

    // wrapping age
    assign age        = now_ms - slot_lu;
    assign ev.empty   = (slot_key == '0);
    assign ev.expired = (age > timeout_ms);
    assign ev.live    = (slot_key != '0) && (age <= timeout_ms);
    assign ev.match   = (slot_key == req_key);

endmodule

// File: hdl/session_token_table_top.sv
// Each request runs SCAN, WRITE, COUNT and DONE before a new one is taken;
// the shared slot evaluator walks the table once to search/clean, then the
// WRITE state acts on the picked slot, and it walks the table once more to count.
// req_ready is high only while idle; a finished beat waits in the response register.
// Reset: asynchronous, all slots empty with time 0, timeout_ms = 1800000.
module session_token_table_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [stt_pkg::TIME_W-1:0]  cfg_data,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [1:0]                  kind,
    input  logic [stt_pkg::TOKEN_W-1:0] token_key,
    input  logic [stt_pkg::TIME_W-1:0]  now_ms,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic                        ok,
    output logic [stt_pkg::CNT_W-1:0]   active_count
);

    localparam logic [stt_pkg::IDX_W-1:0] LAST_IDX = stt_pkg::IDX_W'(stt_pkg::SESSIONS - 1);

    stt_pkg::state_t state_reg, state_next;

    logic [stt_pkg::KEY_W-1:0]  slot_key_reg [stt_pkg::SESSIONS];
    logic [stt_pkg::TIME_W-1:0] slot_lu_reg  [stt_pkg::SESSIONS];

    logic [stt_pkg::TIME_W-1:0] timeout_reg;
    stt_pkg::kind_t             kind_reg, kind_next;
    logic [stt_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [stt_pkg::TIME_W-1:0] now_reg, now_next;
    logic [stt_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [stt_pkg::IDX_W-1:0]  pick_reg, pick_next;
    logic [stt_pkg::TIME_W-1:0] min_reg, min_next;
    logic                       hit_reg, hit_next;
    logic                       ok_reg, ok_next;
    logic [stt_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    logic                       ok_out_reg, ok_out_next;
    logic [stt_pkg::CNT_W-1:0]  cnt_out_reg, cnt_out_next;

    logic                       slot_we;
    logic [stt_pkg::IDX_W-1:0]  slot_widx;
    logic [stt_pkg::KEY_W-1:0]  slot_wkey;
    logic [stt_pkg::TIME_W-1:0] slot_wlu;

    logic [stt_pkg::IDX_W-1:0]  sel_idx;
    stt_pkg::slot_eval_t        ev;
    logic                       req_beat;
    logic                       clr;
    logic                       eff_empty;
    logic [stt_pkg::TIME_W-1:0] eff_lu;

    assign req_ready = (state_reg == stt_pkg::ST_IDLE);
    assign req_beat  = req_valid && req_ready;
    assign sel_idx   = (state_reg == stt_pkg::ST_WRITE) ? pick_reg : idx_reg;

    stt_slot_eval u_eval (
        .slot_key   (slot_key_reg[sel_idx]),
        .slot_lu    (slot_lu_reg[sel_idx]),
        .req_key    (key_reg),
        .now_ms     (now_reg),
        .timeout_ms (timeout_reg),
        .ev         (ev)
    );

    assign clr       = !ev.empty && ev.expired;
    assign eff_empty = ev.empty || clr;
    assign eff_lu    = clr ? '0 : slot_lu_reg[sel_idx];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            stt_pkg::ST_IDLE:
            begin
                if (req_valid)
                    state_next = stt_pkg::ST_SCAN;
            end
            stt_pkg::ST_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                    state_next = stt_pkg::ST_WRITE;
            end
            stt_pkg::ST_WRITE:
                state_next = stt_pkg::ST_COUNT;
            stt_pkg::ST_COUNT:
            begin
                if (idx_reg == LAST_IDX)
                    state_next = stt_pkg::ST_DONE;
            end
            stt_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                    state_next = stt_pkg::ST_IDLE;
            end
            default:
                state_next = stt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        kind_next      = kind_reg;
        key_next       = key_reg;
        now_next       = now_reg;
        idx_next       = idx_reg;
        pick_next      = pick_reg;
        min_next       = min_reg;
        hit_next       = hit_reg;
        ok_next        = ok_reg;
        cnt_next       = cnt_reg;
        ok_out_next    = ok_out_reg;
        cnt_out_next   = cnt_out_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        slot_we        = 1'b0;
        slot_widx      = sel_idx;
        slot_wkey      = '0;
        slot_wlu       = '0;

        unique case (state_reg)
            stt_pkg::ST_IDLE:
            begin
                if (req_beat)
                begin
                    kind_next = stt_pkg::kind_t'(kind);
                    key_next  = token_key[stt_pkg::KEY_W-1:0];
                    now_next  = now_ms;
                    idx_next  = '0;
                    pick_next = '0;
                    min_next  = '0;
                    hit_next  = 1'b0;
                    ok_next   = 1'b0;
                    cnt_next  = '0;
                end
            end
            stt_pkg::ST_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (kind_reg == stt_pkg::KIND_STORE)
                begin
                    // drop expired slot, then track first empty or oldest
                    if (clr)
                        slot_we = 1'b1;
                    if (!hit_reg)
                    begin
                        if (eff_empty)
                        begin
                            hit_next  = 1'b1;
                            pick_next = idx_reg;
                        end
                        else if (idx_reg == '0 || eff_lu < min_reg)
                        begin
                            min_next  = eff_lu;
                            pick_next = idx_reg;
                        end
                    end
                end
                else if (!hit_reg && ev.match
                         && !(kind_reg == stt_pkg::KIND_VALIDATE && key_reg == '0))
                begin
                    hit_next  = 1'b1;
                    pick_next = idx_reg;
                end
                if (idx_reg == LAST_IDX)
                    idx_next = '0;
            end
            stt_pkg::ST_WRITE:
            begin
                slot_widx = pick_reg;
                unique case (kind_reg)
                    stt_pkg::KIND_STORE:
                    begin
                        slot_we   = 1'b1;
                        slot_wkey = key_reg;
                        slot_wlu  = now_reg;
                        ok_next   = 1'b1;
                    end
                    stt_pkg::KIND_VALIDATE:
                    begin
                        if (hit_reg)
                        begin
                            if (ev.expired)
                            begin
                                // key cleared, time kept
                                slot_we  = 1'b1;
                                slot_wlu = slot_lu_reg[pick_reg];
                            end
                            else
                                ok_next = 1'b1;
                        end
                    end
                    stt_pkg::KIND_REFRESH:
                    begin
                        if (hit_reg)
                        begin
                            slot_we   = 1'b1;
                            slot_wkey = slot_key_reg[pick_reg];
                            slot_wlu  = now_reg;
                            ok_next   = 1'b1;
                        end
                    end
                    stt_pkg::KIND_INVALIDATE:
                    begin
                        if (hit_reg)
                        begin
                            slot_we = 1'b1;
                            ok_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        slot_we = 1'b0;
                    end
                endcase
            end
            stt_pkg::ST_COUNT:
            begin
                idx_next = idx_reg + 1'b1;
                if (ev.live && cnt_reg != '1)
                    cnt_next = cnt_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                    idx_next = '0;
            end
            stt_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    ok_out_next    = ok_reg;
                    cnt_out_next   = cnt_reg;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stt_pkg::ST_IDLE;
            timeout_reg   <= stt_pkg::TIMEOUT_RESET;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            ok_reg        <= 1'b0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < stt_pkg::SESSIONS; i++)
            begin
                slot_key_reg[i] <= '0;
                slot_lu_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            hit_reg       <= hit_next;
            ok_reg        <= ok_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
                timeout_reg <= cfg_data;
            if (slot_we)
            begin
                slot_key_reg[slot_widx] <= slot_wkey;
                slot_lu_reg[slot_widx]  <= slot_wlu;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        key_reg     <= key_next;
        now_reg     <= now_next;
        pick_reg    <= pick_next;
        min_reg     <= min_next;
        ok_out_reg  <= ok_out_next;
        cnt_out_reg <= cnt_out_next;
    end

    assign rsp_valid    = rsp_valid_reg;
    assign ok           = ok_out_reg;
    assign active_count = cnt_out_reg;

`include "session_token_table_top_assert.svh"

    `STT_ASSERT_NEXT(a_accept_starts_scan, req_beat, state_reg == stt_pkg::ST_SCAN && idx_reg == '0)
    `STT_ASSERT_NEXT(a_store_ok, state_reg == stt_pkg::ST_WRITE && kind_reg == stt_pkg::KIND_STORE, ok_reg)
    `STT_ASSERT_NEXT(a_count_to_done, state_reg == stt_pkg::ST_COUNT && idx_reg == LAST_IDX, state_reg == stt_pkg::ST_DONE)
    `STT_ASSERT_NOW(a_count_bound, 1'b1, cnt_reg <= stt_pkg::CNT_W'(stt_pkg::SESSIONS))

endmodule
